FILE: sv/rbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbq_pkg
// Shared constants, payload type and width helpers for the rotation basis to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package rbq_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int IN_W          = 16;
   localparam int OUT_W         = 16;
   localparam int MAG_W         = 30;   // normalized magnitude, top bit at 2^29
   localparam int MAG_TOP       = 29;
   localparam int SUM_W         = 62;   // sum of four squared magnitudes
   localparam int ROOT_W        = 31;   // floor sqrt of the sum

   // Payload carried alongside the norm computation.
   typedef struct packed {
      logic                  ident;
      logic [3:0]            neg;
      logic [3:0][MAG_W-1:0] mag;
   } rbq_pay_type;

   // Width of the signed branch terms at 2*frac fraction bits.
   function automatic int qw_of(input int frac);
      int a;
      a = (2 * frac > frac + 15) ? 2 * frac : frac + 15;
      return ((a > 31) ? a : 31) + 4;
   endfunction

   function automatic int clog2_of(input int n);
      int r;
      r = 0;
      while ((1 << r) < n) r = r + 1;
      return r;
   endfunction

endpackage

FILE: sv/rbq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbq_front
// Cross product, branch selection and component magnitudes (three stages).
// ----------------------------------------------------------------------------
module rbq_front #(
   parameter int FRAC_BITS = rbq_pkg::FRAC_BITS_DEF,
   parameter int QW        = rbq_pkg::qw_of(rbq_pkg::FRAC_BITS_DEF)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [5:0][rbq_pkg::IN_W-1:0] in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [3:0][QW-1:0]         out_mag,
   output logic [3:0]                 out_neg,
   output logic                       out_ident
);
   import rbq_pkg::*;

   localparam logic signed [QW-1:0] ONE = QW'(64'd1 << (2 * FRAC_BITS));
   localparam logic signed [QW-1:0] EPS = QW'((64'd1 << (2 * FRAC_BITS)) / 64'd10000);

   logic [2:0] vld_ff;
   logic [2:0] en;

   always_comb begin
      en[2] = !vld_ff[2] || out_ready;
      en[1] = !vld_ff[1] || en[2];
      en[0] = !vld_ff[0] || en[1];
   end
   assign in_ready  = en[0];
   assign out_valid = vld_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         if (en[1]) vld_ff[1] <= vld_ff[0];
         if (en[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   // stage 1: inputs and cross-product partial products
   logic [5:0][IN_W-1:0]    a_ff;
   logic signed [31:0]      p_ff [6];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_ff     <= in_data;
         p_ff[0]  <= $signed(in_data[1]) * $signed(in_data[5]);
         p_ff[1]  <= $signed(in_data[2]) * $signed(in_data[4]);
         p_ff[2]  <= $signed(in_data[2]) * $signed(in_data[3]);
         p_ff[3]  <= $signed(in_data[0]) * $signed(in_data[5]);
         p_ff[4]  <= $signed(in_data[0]) * $signed(in_data[4]);
         p_ff[5]  <= $signed(in_data[1]) * $signed(in_data[3]);
      end
   end

   // stage 2: branch terms
   logic signed [QW-1:0] nx, ny, nz, sux, suy, suz, svx, svy, svz, rt;
   logic signed [QW-1:0] q_in [4];
   logic signed [QW-1:0] r_in;
   logic signed [QW-1:0] q_ff [4];
   logic signed [QW-1:0] r_ff;

   always_comb begin
      nx  = QW'(p_ff[0]) - QW'(p_ff[1]);
      ny  = QW'(p_ff[2]) - QW'(p_ff[3]);
      nz  = QW'(p_ff[4]) - QW'(p_ff[5]);
      sux = QW'($signed(a_ff[0])) <<< FRAC_BITS;
      suy = QW'($signed(a_ff[1])) <<< FRAC_BITS;
      suz = QW'($signed(a_ff[2])) <<< FRAC_BITS;
      svx = QW'($signed(a_ff[3])) <<< FRAC_BITS;
      svy = QW'($signed(a_ff[4])) <<< FRAC_BITS;
      svz = QW'($signed(a_ff[5])) <<< FRAC_BITS;
      rt  = ONE + sux + svy + nz;
      if (rt > EPS) begin
         r_in = rt;
         q_in[0] = rt;          q_in[1] = svz - ny;
         q_in[2] = nx - suz;    q_in[3] = suy - svx;
      end else if (sux > svy && sux > nz) begin
         r_in = ONE + sux - svy - nz;
         q_in[0] = svz - ny;    q_in[1] = r_in;
         q_in[2] = suy + svx;   q_in[3] = nx + suz;
      end else if (svy > nz) begin
         r_in = ONE - sux + svy - nz;
         q_in[0] = nx - suz;    q_in[1] = suy + svx;
         q_in[2] = r_in;        q_in[3] = svz + ny;
      end else begin
         r_in = ONE - sux - svy + nz;
         q_in[0] = suy - svx;   q_in[1] = nx + suz;
         q_in[2] = svz + ny;    q_in[3] = r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   // stage 3: sign and magnitude, identity fallback flag
   logic [3:0][QW-1:0] mag_ff;
   logic [3:0]         neg_ff;
   logic               ident_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < 4; i++) begin
            neg_ff[i] <= q_ff[i][QW-1];
            mag_ff[i] <= q_ff[i][QW-1] ? QW'(-q_ff[i]) : QW'(q_ff[i]);
         end
         ident_ff <= (r_ff <= 0);
      end
   end

   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;
   assign out_ident = ident_ff;

endmodule

FILE: sv/rbq_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbq_norm
// Common shift of the magnitudes that puts the largest into [2^29, 2^30)
// and sum of squares (five stages).
// ----------------------------------------------------------------------------
module rbq_norm #(
   parameter int QW = rbq_pkg::qw_of(rbq_pkg::FRAC_BITS_DEF)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [3:0][QW-1:0]          in_mag,
   input  logic [3:0]                  in_neg,
   input  logic                        in_ident,
   output logic                        out_valid,
   input  logic                        out_ready,
   output rbq_pkg::rbq_pay_type        out_pay,
   output logic [rbq_pkg::SUM_W-1:0]   out_sum
);
   import rbq_pkg::*;

   localparam int PW = clog2_of(QW);

   logic [4:0] vld_ff;
   logic [4:0] en;

   always_comb begin
      en[4] = !vld_ff[4] || out_ready;
      for (int k = 3; k >= 0; k--) en[k] = !vld_ff[k] || en[k+1];
   end
   assign in_ready  = en[0];
   assign out_valid = vld_ff[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < 5; k++) if (en[k]) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // stage 1: OR of magnitudes shares the leading one of the maximum
   logic [3:0][QW-1:0] m1_ff;
   logic [3:0]         n1_ff;
   logic               i1_ff;
   logic [QW-1:0]      or_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         m1_ff <= in_mag;
         n1_ff <= in_neg;
         i1_ff <= in_ident;
         or_ff <= in_mag[0] | in_mag[1] | in_mag[2] | in_mag[3];
      end
   end

   // stage 2: leading one position
   logic [PW-1:0]      pos_in;
   logic [3:0][QW-1:0] m2_ff;
   logic [3:0]         n2_ff;
   logic               i2_ff;
   logic [PW-1:0]      pos_ff;

   always_comb begin
      pos_in = '0;
      for (int i = 0; i < QW; i++) if (or_ff[i]) pos_in = PW'(i);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         m2_ff  <= m1_ff;
         n2_ff  <= n1_ff;
         i2_ff  <= i1_ff;
         pos_ff <= pos_in;
      end
   end

   // stage 3: shift; right shifts truncate
   rbq_pay_type pay3_in, pay3_ff;
   logic [QW-1:0] sh;

   always_comb begin
      pay3_in.ident = i2_ff;
      pay3_in.neg   = n2_ff;
      for (int i = 0; i < 4; i++) begin
         if (pos_ff > PW'(MAG_TOP)) sh = m2_ff[i] >> (pos_ff - PW'(MAG_TOP));
         else                       sh = m2_ff[i] << (PW'(MAG_TOP) - pos_ff);
         pay3_in.mag[i] = sh[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) pay3_ff <= pay3_in;
   end

   // stage 4: squares
   rbq_pay_type            pay4_ff;
   logic [2*MAG_W-1:0]     sq_ff [4];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         pay4_ff <= pay3_ff;
         for (int i = 0; i < 4; i++) sq_ff[i] <= pay3_ff.mag[i] * pay3_ff.mag[i];
      end
   end

   // stage 5: sum
   rbq_pay_type        pay5_ff;
   logic [SUM_W-1:0]   sum_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         pay5_ff <= pay4_ff;
         sum_ff  <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2])
                  + SUM_W'(sq_ff[3]);
      end
   end

   assign out_pay = pay5_ff;
   assign out_sum = sum_ff;

endmodule

FILE: sv/rbq_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbq_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rbq_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  rbq_pkg::rbq_pay_type         in_pay,
   input  logic [rbq_pkg::SUM_W-1:0]    in_sum,
   output logic                         out_valid,
   input  logic                         out_ready,
   output rbq_pkg::rbq_pay_type         out_pay,
   output logic [rbq_pkg::ROOT_W-1:0]   out_root
);
   import rbq_pkg::*;

   localparam int S = ROOT_W;

   logic [S-1:0]       vld_ff;
   logic [S-1:0]       en;
   logic [SUM_W-1:0]   rem_ff  [S];
   logic [ROOT_W-1:0]  root_ff [S];
   rbq_pay_type        pay_ff  [S];

   always_comb begin
      en[S-1] = !vld_ff[S-1] || out_ready;
      for (int k = S - 2; k >= 0; k--) en[k] = !vld_ff[k] || en[k+1];
   end
   assign in_ready  = en[0];
   assign out_valid = vld_ff[S-1];
   assign out_pay   = pay_ff[S-1];
   assign out_root  = root_ff[S-1];

   for (genvar k = 0; k < S; k++) begin : g_stage
      localparam int B = S - 1 - k;
      logic [SUM_W-1:0]  rem_src, trial;
      logic [ROOT_W-1:0] root_src;
      logic              v_src;
      rbq_pay_type       pay_src;

      if (k == 0) begin : g_first
         assign rem_src  = in_sum;
         assign root_src = '0;
         assign v_src    = in_valid;
         assign pay_src  = in_pay;
      end else begin : g_rest
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign v_src    = vld_ff[k-1];
         assign pay_src  = pay_ff[k-1];
      end

      // (root + 2^B)^2 - root^2
      assign trial = (SUM_W'(root_src) << (B + 1)) + (SUM_W'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en[k]) begin
            vld_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            pay_ff[k] <= pay_src;
            if (rem_src >= trial) begin
               rem_ff[k]  <= rem_src - trial;
               root_ff[k] <= root_src | (ROOT_W'(1) << B);
            end else begin
               rem_ff[k]  <= rem_src;
               root_ff[k] <= root_src;
            end
         end
      end
   end

endmodule

FILE: sv/rbq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbq_div
// Rounded division of each magnitude by the norm, one quotient bit per
// stage on four lanes, then sign, saturation and identity fallback.
// ----------------------------------------------------------------------------
module rbq_div #(
   parameter int FRAC_BITS = rbq_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  rbq_pkg::rbq_pay_type         in_pay,
   input  logic [rbq_pkg::ROOT_W-1:0]   in_norm,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [3:0][rbq_pkg::OUT_W-1:0] out_q
);
   import rbq_pkg::*;

   localparam int QB = FRAC_BITS + 2;            // quotient bits
   localparam int DW = ROOT_W + QB;              // remainder width
   localparam int S  = QB + 1;                   // divide stages plus output
   localparam logic [OUT_W-1:0] IDENT_W =
      (FRAC_BITS >= OUT_W - 1) ? OUT_W'(32767) : OUT_W'(64'd1 << FRAC_BITS);

   logic [S-1:0]       vld_ff;
   logic [S-1:0]       en;
   logic [DW-1:0]      rem_ff  [QB][4];
   logic [QB-1:0]      quo_ff  [QB][4];
   logic [ROOT_W-1:0]  norm_ff [QB];
   logic [3:0]         neg_ff  [QB];
   logic               id_ff   [QB];

   always_comb begin
      en[S-1] = !vld_ff[S-1] || out_ready;
      for (int k = S - 2; k >= 0; k--) en[k] = !vld_ff[k] || en[k+1];
   end
   assign in_ready  = en[0];
   assign out_valid = vld_ff[S-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < S; k++) if (en[k]) vld_ff[k] <= vld_ff[k-1];
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int B = QB - 1 - k;
      logic [DW-1:0]     rem_src [4];
      logic [QB-1:0]     quo_src [4];
      logic [ROOT_W-1:0] norm_src;
      logic [3:0]        neg_src;
      logic              id_src;
      logic [DW-1:0]     dsh;

      if (k == 0) begin : g_first
         // numerator m * 2^F + norm / 2
         for (genvar i = 0; i < 4; i++) begin : g_lane
            assign rem_src[i] = (DW'(in_pay.mag[i]) << FRAC_BITS) + DW'(in_norm >> 1);
            assign quo_src[i] = '0;
         end
         assign norm_src = in_norm;
         assign neg_src  = in_pay.neg;
         assign id_src   = in_pay.ident;
      end else begin : g_rest
         for (genvar i = 0; i < 4; i++) begin : g_lane
            assign rem_src[i] = rem_ff[k-1][i];
            assign quo_src[i] = quo_ff[k-1][i];
         end
         assign norm_src = norm_ff[k-1];
         assign neg_src  = neg_ff[k-1];
         assign id_src   = id_ff[k-1];
      end

      assign dsh = DW'(norm_src) << B;

      always_ff @(posedge clock) begin
         if (en[k]) begin
            norm_ff[k] <= norm_src;
            neg_ff[k]  <= neg_src;
            id_ff[k]   <= id_src;
            for (int i = 0; i < 4; i++) begin
               if (rem_src[i] >= dsh) begin
                  rem_ff[k][i] <= rem_src[i] - dsh;
                  quo_ff[k][i] <= quo_src[i] | (QB'(1) << B);
               end else begin
                  rem_ff[k][i] <= rem_src[i];
                  quo_ff[k][i] <= quo_src[i];
               end
            end
         end
      end
   end

   // output: sign, saturate, identity fallback
   logic [3:0][OUT_W-1:0] o_in, o_ff;
   logic [32:0]           v;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         v = 33'(quo_ff[QB-1][i]);
         if (neg_ff[QB-1][i] && v != '0) begin
            if (v > 33'd32768) v = 33'd32768;
            o_in[i] = OUT_W'(-v);
         end else begin
            if (v > 33'd32767) v = 33'd32767;
            o_in[i] = OUT_W'(v);
         end
      end
      if (id_ff[QB-1]) begin
         o_in[0] = IDENT_W;
         o_in[1] = '0;
         o_in[2] = '0;
         o_in[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[S-1]) o_ff <= o_in;
   end

   assign out_q = o_ff;

endmodule

FILE: sv/rotation_basis_to_quaternion_top.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; each stage holds its item only while the
// stage after it is full and stalled, so input stalls only when every stage is full.
// Depth is set by the one-bit-per-stage square root (31) and divider (F+2).
// Reset: synchronous, active high, clears all stage valid bits.
// ----------------------------------------------------------------------------
// rotation_basis_to_quaternion_top
// Turns two orthonormal basis vectors into a unit quaternion in Q2.14.
// ----------------------------------------------------------------------------
module rotation_basis_to_quaternion_top #(
   parameter int FRAC_BITS = rbq_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // ux, uy, uz, vx_in, vy_in, vz_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // qw, qx, qy, qz
);
   import rbq_pkg::*;

   localparam int QW = qw_of(FRAC_BITS);

   logic [5:0][IN_W-1:0] in_data;
   logic [3:0][QW-1:0]   f_mag;
   logic [3:0]           f_neg;
   logic                 f_ident, f_valid, f_ready;
   rbq_pay_type          n_pay, s_pay;
   logic [SUM_W-1:0]     n_sum;
   logic                 n_valid, n_ready, s_valid, s_ready;
   logic [ROOT_W-1:0]    s_root;
   logic [3:0][OUT_W-1:0] q;

   assign in_data = req_tdata;

   rbq_front #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(in_data),
      .out_valid(f_valid), .out_ready(f_ready),
      .out_mag(f_mag), .out_neg(f_neg), .out_ident(f_ident)
   );

   rbq_norm #(.QW(QW)) u_norm (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready),
      .in_mag(f_mag), .in_neg(f_neg), .in_ident(f_ident),
      .out_valid(n_valid), .out_ready(n_ready),
      .out_pay(n_pay), .out_sum(n_sum)
   );

   rbq_sqrt u_sqrt (
      .clock, .reset,
      .in_valid(n_valid), .in_ready(n_ready), .in_pay(n_pay), .in_sum(n_sum),
      .out_valid(s_valid), .out_ready(s_ready), .out_pay(s_pay), .out_root(s_root)
   );

   rbq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock, .reset,
      .in_valid(s_valid), .in_ready(s_ready), .in_pay(s_pay), .in_norm(s_root),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_q(q)
   );

   assign rsp_tdata = q;

endmodule

FILE: tb/sv/rbq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbq_checker
// Watches the basis-vector and quaternion streams, computes the expected unit
// quaternion for every accepted basis pair and compares results in order.
// ----------------------------------------------------------------------------
module rbq_checker #(
   parameter int FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   output int          fail_count,
   output int          pending,
   output int          quat_count
);

   logic [63:0] quat_queue[$];

   function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] clip(input bit neg, input logic [63:0] mag);
      if (neg) begin
         if (mag > 32768) mag = 32768;
         return 16'(-mag);
      end
      if (mag > 32767) mag = 32767;
      return mag[15:0];
   endfunction

   function automatic logic [63:0] quat_of(input logic [95:0] d);
      longint one, eps, sc, ux, uy, uz, vx, vy, vz, nx, ny, nz;
      longint bux, buy, buz, bvx, bvy, bvz, r;
      longint q[4];
      logic [63:0] m[4];
      logic [63:0] mx, sum, norm, v, res;
      bit ng[4];
      one = longint'(1) << (2 * FRAC_BITS);
      eps = one / 10000;
      sc  = longint'(1) << FRAC_BITS;
      ux = $signed(d[15:0]);  uy = $signed(d[31:16]); uz = $signed(d[47:32]);
      vx = $signed(d[63:48]); vy = $signed(d[79:64]); vz = $signed(d[95:80]);
      nx = uy * vz - uz * vy;
      ny = uz * vx - ux * vz;
      nz = ux * vy - uy * vx;
      bux = ux * sc; buy = uy * sc; buz = uz * sc;
      bvx = vx * sc; bvy = vy * sc; bvz = vz * sc;
      r = one + bux + bvy + nz;
      if (r > eps) begin
         q[0] = r; q[1] = bvz - ny; q[2] = nx - buz; q[3] = buy - bvx;
      end else if (bux > bvy && bux > nz) begin
         r = one + bux - bvy - nz;
         q[0] = bvz - ny; q[1] = r; q[2] = buy + bvx; q[3] = nx + buz;
      end else if (bvy > nz) begin
         r = one - bux + bvy - nz;
         q[0] = nx - buz; q[1] = buy + bvx; q[2] = r; q[3] = bvz + ny;
      end else begin
         r = one - bux - bvy + nz;
         q[0] = buy - bvx; q[1] = nx + buz; q[2] = bvz + ny; q[3] = r;
      end
      // degenerate fallback gives the identity
      if (r <= 0) return {48'd0, clip(0, 64'd1 << FRAC_BITS)};
      mx = 0;
      for (int i = 0; i < 4; i++) begin
         ng[i] = q[i] < 0;
         m[i] = ng[i] ? -q[i] : q[i];
         if (m[i] > mx) mx = m[i];
      end
      while (mx >= (64'd1 << 30)) begin
         mx = mx >> 1;
         for (int i = 0; i < 4; i++) m[i] = m[i] >> 1;
      end
      while (mx < (64'd1 << 29)) begin
         mx = mx << 1;
         for (int i = 0; i < 4; i++) m[i] = m[i] << 1;
      end
      sum = 0;
      for (int i = 0; i < 4; i++) sum = sum + m[i] * m[i];
      norm = sqrt_floor(sum);
      res = 0;
      for (int i = 0; i < 4; i++) begin
         v = ((m[i] << FRAC_BITS) + norm / 2) / norm;
         res[16*i +: 16] = clip(ng[i] && v != 0, v);
      end
      return res;
   endfunction

   assign pending = quat_queue.size();

   always @(posedge clock) begin
      logic [63:0] want;
      if (reset) begin
         fail_count <= 0;
         quat_count <= 0;
      end else begin
         if (req_tvalid && req_tready) quat_queue.push_back(quat_of(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            quat_count <= quat_count + 1;
            if (quat_queue.size() == 0) begin
               $error("quaternion with none expected: %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = quat_queue.pop_front();
               if (rsp_tdata[15:0] !== want[15:0])
                  $error("qw expected %h actual %h", want[15:0], rsp_tdata[15:0]);
               if (rsp_tdata[31:16] !== want[31:16])
                  $error("qx expected %h actual %h", want[31:16], rsp_tdata[31:16]);
               if (rsp_tdata[47:32] !== want[47:32])
                  $error("qy expected %h actual %h", want[47:32], rsp_tdata[47:32]);
               if (rsp_tdata[63:48] !== want[63:48])
                  $error("qz expected %h actual %h", want[63:48], rsp_tdata[63:48]);
               if (rsp_tdata !== want) fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds rotations, near-singular and malformed basis pairs into the
// quaternion pipeline with random gaps and back-pressure; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LATENCY = rbq_pkg::FRAC_BITS_DEF + 42;
   localparam int ONE     = 1 << rbq_pkg::FRAC_BITS_DEF;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   int          fail_count, pending, quat_count;
   int          hold_off = 0;
   bit          feed_done = 0;

   always #1 clock = ~clock;

   rotation_basis_to_quaternion_top dut (.*);

   rbq_checker #(.FRAC_BITS(rbq_pkg::FRAC_BITS_DEF)) u_checker (.*);

   // Leaves tvalid high on return; the next call or the caller drops it.
   task automatic send_basis(input int ux, uy, uz, vx, vy, vz);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {16'(vz), 16'(vy), 16'(vx), 16'(uz), 16'(uy), 16'(ux)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Random rotation: a random angle about z or y, maybe a half turn about y or x, then perturb.
   task automatic send_rotation(input int jitter);
      int c, s, k;
      int a[3], b[3];
      c = $urandom_range(0, 2 * ONE) - ONE;
      s = $urandom_range(0, 1) ? 1 : -1;
      s = s * int'($sqrt(real'(ONE) * ONE - real'(c) * c));
      k = $urandom_range(0, 5);
      a = '{c, s, 0};
      b = '{-s, c, 0};
      if (k >= 3) begin
         a = '{c, 0, -s};
         b = '{0, ONE, 0};
      end
      if (k == 1 || k == 4) begin
         a = '{-a[0], a[1], -a[2]};
         b = '{-b[0], b[1], -b[2]};
      end
      if (k == 2 || k == 5) begin
         a = '{a[0], -a[1], -a[2]};
         b = '{b[0], -b[1], -b[2]};
      end
      for (int i = 0; i < 3; i++) begin
         a[i] = a[i] + $urandom_range(0, 2 * jitter) - jitter;
         b[i] = b[i] + $urandom_range(0, 2 * jitter) - jitter;
      end
      send_basis(a[0], a[1], a[2], b[0], b[1], b[2]);
   endtask

   // Drain side: random stalls, one long hold-off during the random part.
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         if (hold_off > 0) begin
            rsp_tready <= 0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int wait_cycles;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: identity, half turns about each axis, extremes, degenerate
      send_basis(ONE, 0, 0, 0, ONE, 0);
      send_basis(ONE, 0, 0, 0, -ONE, 0);
      send_basis(-ONE, 0, 0, 0, ONE, 0);
      send_basis(-ONE, 0, 0, 0, -ONE, 0);
      send_basis(0, ONE, 0, -ONE, 0, 0);
      send_basis(0, 0, -ONE, 0, ONE, 0);
      send_basis(0, 0, ONE, ONE, 0, 0);
      send_basis(0, 0, 0, 0, 0, 0);
      send_basis(-32768, -32768, -32768, -32768, -32768, -32768);
      send_basis(32767, 32767, 32767, 32767, 32767, 32767);
      send_basis(-32768, 0, 0, 0, -32768, 0);
      send_basis(32767, -32768, 32767, -32768, 32767, -32768);
      send_basis(-ONE, 0, 0, 0, 0, 0);
      send_basis(0, 0, 0, 0, -ONE, 0);
      send_basis(-ONE, 1, 0, 0, -ONE, 0);
      send_basis(-ONE + 2, 0, 0, 0, 0, 0);
      send_basis(ONE / 2, 0, 0, 0, 0, 0);
      // trace just around the threshold
      send_basis(-ONE / 2, 0, 0, 0, -ONE / 2, 0);
      send_basis(-ONE, 0, 0, 0, 1, 0);
      for (int n = 0; n < 1530; n++) begin
         if (n == 700) hold_off = 300;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_rotation(0);
            4, 5:       send_rotation(40);
            6:          send_rotation(3000);
            default:    send_basis($urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom);
         endcase
      end
      req_tvalid <= 0;
      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent 1549 basis pairs (axis rotations, noisy and raw random)");
      $display("and checked %0d quaternions under random back-pressure.", quat_count);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/rbq_pkg.sv
sv/rbq_front.sv
sv/rbq_norm.sv
sv/rbq_sqrt.sv
sv/rbq_div.sv
sv/rotation_basis_to_quaternion_top.sv
tb/sv/rbq_checker.sv
tb/sv/testbench.sv
